// ----- design/rtlm_pkg.sv -----
// Shared types and constants for the radial-tangential lens model.
// Holds the payload structs, configuration register indexes and fixed-point constants.
// No dependencies.
`default_nettype none

package rtlm_pkg;

  // Payload of one input transfer: image-plane point, signed Q16.16.
  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } rtlm_in_t;

  // Payload of one result transfer: mapped point, signed Q16.16, plus clip flag.
  typedef struct packed {
    logic signed [31:0] mapped_x;
    logic signed [31:0] mapped_y;
    logic               saturated;
  } rtlm_out_t;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_K1 = 3'd0,
    CFG_K2 = 3'd1,
    CFG_K3 = 3'd2,
    CFG_P1 = 3'd3,
    CFG_P2 = 3'd4
  } rtlm_cfg_idx_t;

  // Register stages between input and output, output register included.
  localparam int unsigned STG_NUM = 13;

  // Clamp value for r2, r4 and r6 (2^63 - 1, unsigned Q31.32).
  localparam logic [62:0] R_MAX = {63{1'b1}};

  // 1.0 in the Q.60 polynomial accumulator.
  localparam logic signed [97:0] ONE_Q60 = {{37{1'b0}}, 1'b1, 60'd0};

  // Rounding constant for the final Q.60 -> Q16.16 shift.
  localparam logic signed [109:0] HALF_Q44 = {{66{1'b0}}, 1'b1, 43'd0};

  // Limits of the F scale factor (signed 64 bit).
  localparam logic signed [63:0] F_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] F_MIN = {1'b1, {63{1'b0}}};

  // Output limits (signed Q16.16).
  localparam logic signed [31:0] SAT_MAX = {1'b0, {31{1'b1}}};
  localparam logic signed [31:0] SAT_MIN = {1'b1, {31{1'b0}}};

endpackage

`default_nettype wire

// ----- design/radial_tangential_lens_model.sv -----
// Top level of the radial-tangential (Brown-Conrady K1..K3, P1, P2) lens model.
// Thirteen-stage multiply/add pipeline with a coefficient register file.
// Depends on rtlm_pkg.
//
//   channel  | ports                              | direction | payload
//   ---------+------------------------------------+-----------+---------------------------
//   input    | in_valid, in_stall, in_data        | in        | point_x, point_y (Q16.16)
//   result   | out_valid, out_stall, out_data     | out       | mapped_x, mapped_y, saturated
//   config   | cfg_we, cfg_idx, cfg_wdata         | in        | K1, K2, K3, P1, P2 (Q4.28)
//
// Throughput is one point per cycle while the result channel is not stalled. A result passes
// through every register stage, the output register last, before it is presented. The
// depth is set by the r2 -> r4 -> r6 -> F -> x*F dependency chain, where every 63-bit
// product is cut into 32-bit partial products and summed in the following stage.
// Reset (rst_n low, synchronous) empties the pipeline and clears all coefficients to zero.
// A stall holds only the stages that are full back to the output; bubbles still close up,
// so a new point is taken whenever at least one stage is empty or the output moves.
`default_nettype none

module radial_tangential_lens_model
  import rtlm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DAT_W-1:0]  cfg_wdata,
  // input channel
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire rtlm_in_t              in_data,
  // result channel
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      rtlm_out_t             out_data
);

  // ---------------------------------------------------------------------------------------
  // Coefficient registers. Writes to indexes past the last register are dropped.
  // ---------------------------------------------------------------------------------------
  logic signed [31:0] k1_r, k2_r, k3_r, p1_r, p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k1_r <= '0;
      k2_r <= '0;
      k3_r <= '0;
      p1_r <= '0;
      p2_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_K1:  k1_r <= cfg_wdata;
        CFG_K2:  k2_r <= cfg_wdata;
        CFG_K3:  k3_r <= cfg_wdata;
        CFG_P1:  p1_r <= cfg_wdata;
        CFG_P2:  p2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------
  // Pipeline flow control. Stage i may load when the output can move, or when some stage
  // from i down to the output is empty (a bubble to close up).
  // ---------------------------------------------------------------------------------------
  logic [STG_NUM-1:0] vld_r;
  logic [STG_NUM-1:0] adv;
  logic               out_rdy;

  assign out_rdy = !vld_r[STG_NUM-1] || !out_stall;

  always_comb begin
    for (int i = 0; i < STG_NUM; i++) begin
      adv[i] = out_rdy || !(&(vld_r | ~({STG_NUM{1'b1}} << i)));
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld_r[STG_NUM-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int i = 1; i < STG_NUM; i++) begin
        if (adv[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 1: squares and cross product, exact Q32.32.
  // ---------------------------------------------------------------------------------------
  logic signed [31:0] x1_r, y1_r;
  logic signed [63:0] xx1_r, yy1_r, xy1_r;
  logic signed [63:0] xx1_nxt, yy1_nxt, xy1_nxt;

  always_comb begin
    xx1_nxt = in_data.point_x * in_data.point_x;
    yy1_nxt = in_data.point_y * in_data.point_y;
    xy1_nxt = in_data.point_x * in_data.point_y;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      x1_r  <= in_data.point_x;
      y1_r  <= in_data.point_y;
      xx1_r <= xx1_nxt;
      yy1_r <= yy1_nxt;
      xy1_r <= xy1_nxt;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 2: r2 with clamp, and the tangential operands 3xx+yy, xx+3yy, 2xy.
  // ---------------------------------------------------------------------------------------
  logic [63:0]        r2_sum;
  logic signed [65:0] xx_w, yy_w;
  logic [62:0]        r2c2_r, r2c2_nxt;
  logic signed [65:0] sx2_r, sy2_r, d2_r;
  logic signed [65:0] sx2_nxt, sy2_nxt, d2_nxt;
  logic signed [31:0] x2_r, y2_r;

  always_comb begin
    r2_sum   = $unsigned(xx1_r) + $unsigned(yy1_r);
    // r2 reaches 2^63 only when both coordinates are the most negative value
    r2c2_nxt = r2_sum[63] ? R_MAX : r2_sum[62:0];
    xx_w     = 66'(xx1_r);
    yy_w     = 66'(yy1_r);
    sx2_nxt  = (xx_w <<< 1) + xx_w + yy_w;
    sy2_nxt  = (yy_w <<< 1) + yy_w + xx_w;
    d2_nxt   = 66'(xy1_r) <<< 1;
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      r2c2_r <= r2c2_nxt;
      sx2_r  <= sx2_nxt;
      sy2_r  <= sy2_nxt;
      d2_r   <= d2_nxt;
      x2_r   <= x1_r;
      y2_r   <= y1_r;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 3: partial products of r2*r2, K1*r2 and the four tangential products.
  // ---------------------------------------------------------------------------------------
  logic [63:0]        sll3_r, sll3_nxt;
  logic [62:0]        slh3_r, slh3_nxt;
  logic [61:0]        shh3_r, shh3_nxt;
  logic signed [64:0] k1l3_r, k1l3_nxt;
  logic signed [63:0] k1h3_r, k1h3_nxt;
  logic signed [64:0] txal3_r, txbl3_r, tyal3_r, tybl3_r;
  logic signed [64:0] txal3_nxt, txbl3_nxt, tyal3_nxt, tybl3_nxt;
  logic signed [65:0] txah3_r, txbh3_r, tyah3_r, tybh3_r;
  logic signed [65:0] txah3_nxt, txbh3_nxt, tyah3_nxt, tybh3_nxt;
  logic [62:0]        r2c3_r;
  logic signed [31:0] x3_r, y3_r;

  always_comb begin
    sll3_nxt  = r2c2_r[31:0] * r2c2_r[31:0];
    slh3_nxt  = r2c2_r[31:0] * r2c2_r[62:32];
    shh3_nxt  = r2c2_r[62:32] * r2c2_r[62:32];
    k1l3_nxt  = k1_r * $signed({1'b0, r2c2_r[31:0]});
    k1h3_nxt  = k1_r * $signed({1'b0, r2c2_r[62:32]});
    // x: P1*(3xx+yy) and P2*2xy; y: P1*2xy and P2*(xx+3yy)
    txal3_nxt = p1_r * $signed({1'b0, sx2_r[31:0]});
    txah3_nxt = p1_r * $signed(sx2_r[65:32]);
    txbl3_nxt = p2_r * $signed({1'b0, d2_r[31:0]});
    txbh3_nxt = p2_r * $signed(d2_r[65:32]);
    tyal3_nxt = p1_r * $signed({1'b0, d2_r[31:0]});
    tyah3_nxt = p1_r * $signed(d2_r[65:32]);
    tybl3_nxt = p2_r * $signed({1'b0, sy2_r[31:0]});
    tybh3_nxt = p2_r * $signed(sy2_r[65:32]);
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      sll3_r  <= sll3_nxt;
      slh3_r  <= slh3_nxt;
      shh3_r  <= shh3_nxt;
      k1l3_r  <= k1l3_nxt;
      k1h3_r  <= k1h3_nxt;
      txal3_r <= txal3_nxt;
      txah3_r <= txah3_nxt;
      txbl3_r <= txbl3_nxt;
      txbh3_r <= txbh3_nxt;
      tyal3_r <= tyal3_nxt;
      tyah3_r <= tyah3_nxt;
      tybl3_r <= tybl3_nxt;
      tybh3_r <= tybh3_nxt;
      r2c3_r  <= r2c2_r;
      x3_r    <= x2_r;
      y3_r    <= y2_r;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 4: r4 = (r2*r2) >> 32 with clamp, K1*r2, and the tangential products assembled.
  // ---------------------------------------------------------------------------------------
  logic [127:0]       sq_sum;
  logic [62:0]        r4_4_r, r4_4_nxt;
  logic signed [95:0] k1r2_4_r, k1r2_4_nxt;
  logic signed [97:0] txa4_r, txb4_r, tya4_r, tyb4_r;
  logic signed [97:0] txa4_nxt, txb4_nxt, tya4_nxt, tyb4_nxt;
  logic [62:0]        r2c4_r;
  logic signed [31:0] x4_r, y4_r;

  always_comb begin
    // the cross term appears twice in a square
    sq_sum     = 128'(sll3_r) + (128'(slh3_r) << 33) + (128'(shh3_r) << 64);
    r4_4_nxt   = (|sq_sum[127:95]) ? R_MAX : sq_sum[94:32];
    k1r2_4_nxt = (96'(k1h3_r) <<< 32) + 96'(k1l3_r);
    txa4_nxt   = (98'(txah3_r) <<< 32) + 98'(txal3_r);
    txb4_nxt   = (98'(txbh3_r) <<< 32) + 98'(txbl3_r);
    tya4_nxt   = (98'(tyah3_r) <<< 32) + 98'(tyal3_r);
    tyb4_nxt   = (98'(tybh3_r) <<< 32) + 98'(tybl3_r);
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      r4_4_r   <= r4_4_nxt;
      k1r2_4_r <= k1r2_4_nxt;
      txa4_r   <= txa4_nxt;
      txb4_r   <= txb4_nxt;
      tya4_r   <= tya4_nxt;
      tyb4_r   <= tyb4_nxt;
      r2c4_r   <= r2c3_r;
      x4_r     <= x3_r;
      y4_r     <= y3_r;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 5: partial products of r4*r2 and K2*r4; tangential sums per axis.
  // ---------------------------------------------------------------------------------------
  logic [63:0]        cll5_r, cll5_nxt;
  logic [62:0]        clh5_r, chl5_r, clh5_nxt, chl5_nxt;
  logic [61:0]        chh5_r, chh5_nxt;
  logic signed [64:0] k2l5_r, k2l5_nxt;
  logic signed [63:0] k2h5_r, k2h5_nxt;
  logic signed [99:0] tx5_r, ty5_r, tx5_nxt, ty5_nxt;
  logic signed [95:0] k1r2_5_r;
  logic signed [31:0] x5_r, y5_r;

  always_comb begin
    cll5_nxt = r4_4_r[31:0] * r2c4_r[31:0];
    clh5_nxt = r4_4_r[31:0] * r2c4_r[62:32];
    chl5_nxt = r4_4_r[62:32] * r2c4_r[31:0];
    chh5_nxt = r4_4_r[62:32] * r2c4_r[62:32];
    k2l5_nxt = k2_r * $signed({1'b0, r4_4_r[31:0]});
    k2h5_nxt = k2_r * $signed({1'b0, r4_4_r[62:32]});
    tx5_nxt  = 100'(txa4_r) + 100'(txb4_r);
    ty5_nxt  = 100'(tya4_r) + 100'(tyb4_r);
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      cll5_r   <= cll5_nxt;
      clh5_r   <= clh5_nxt;
      chl5_r   <= chl5_nxt;
      chh5_r   <= chh5_nxt;
      k2l5_r   <= k2l5_nxt;
      k2h5_r   <= k2h5_nxt;
      tx5_r    <= tx5_nxt;
      ty5_r    <= ty5_nxt;
      k1r2_5_r <= k1r2_4_r;
      x5_r     <= x4_r;
      y5_r     <= y4_r;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 6: r6 = (r4*r2) >> 32 with clamp, and K2*r4.
  // ---------------------------------------------------------------------------------------
  logic [127:0]       cu_sum;
  logic [62:0]        r6_6_r, r6_6_nxt;
  logic signed [95:0] k2r4_6_r, k2r4_6_nxt;
  logic signed [95:0] k1r2_6_r;
  logic signed [99:0] tx6_r, ty6_r;
  logic signed [31:0] x6_r, y6_r;

  always_comb begin
    cu_sum     = 128'(cll5_r) + ((128'(clh5_r) + 128'(chl5_r)) << 32) + (128'(chh5_r) << 64);
    r6_6_nxt   = (|cu_sum[127:95]) ? R_MAX : cu_sum[94:32];
    k2r4_6_nxt = (96'(k2h5_r) <<< 32) + 96'(k2l5_r);
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      r6_6_r   <= r6_6_nxt;
      k2r4_6_r <= k2r4_6_nxt;
      k1r2_6_r <= k1r2_5_r;
      tx6_r    <= tx5_r;
      ty6_r    <= ty5_r;
      x6_r     <= x5_r;
      y6_r     <= y5_r;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 7: K3*r6 partial products; 1 + K1*r2 + K2*r4 at Q.60.
  // ---------------------------------------------------------------------------------------
  logic signed [64:0] k3l7_r, k3l7_nxt;
  logic signed [63:0] k3h7_r, k3h7_nxt;
  logic signed [97:0] polyp7_r, polyp7_nxt;
  logic signed [99:0] tx7_r, ty7_r;
  logic signed [31:0] x7_r, y7_r;

  always_comb begin
    k3l7_nxt   = k3_r * $signed({1'b0, r6_6_r[31:0]});
    k3h7_nxt   = k3_r * $signed({1'b0, r6_6_r[62:32]});
    polyp7_nxt = ONE_Q60 + 98'(k1r2_6_r) + 98'(k2r4_6_r);
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      k3l7_r   <= k3l7_nxt;
      k3h7_r   <= k3h7_nxt;
      polyp7_r <= polyp7_nxt;
      tx7_r    <= tx6_r;
      ty7_r    <= ty6_r;
      x7_r     <= x6_r;
      y7_r     <= y6_r;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 8: complete the radial polynomial.
  // ---------------------------------------------------------------------------------------
  logic signed [97:0] poly8_r, poly8_nxt;
  logic signed [99:0] tx8_r, ty8_r;
  logic signed [31:0] x8_r, y8_r;

  always_comb begin
    poly8_nxt = polyp7_r + (98'(k3h7_r) <<< 32) + 98'(k3l7_r);
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      poly8_r <= poly8_nxt;
      tx8_r   <= tx7_r;
      ty8_r   <= ty7_r;
      x8_r    <= x7_r;
      y8_r    <= y7_r;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 9: F = floor(poly / 2^28), clamped to signed 64 bit (Q32.32).
  // ---------------------------------------------------------------------------------------
  logic signed [69:0] psh;
  logic               f_fits;
  logic signed [63:0] f9_r, f9_nxt;
  logic signed [99:0] tx9_r, ty9_r;
  logic signed [31:0] x9_r, y9_r;

  always_comb begin
    psh    = $signed(poly8_r[97:28]);
    f_fits = (&psh[69:63]) || !(|psh[69:63]);
    if (f_fits) begin
      f9_nxt = psh[63:0];
    end else if (psh[69]) begin
      f9_nxt = F_MIN;
    end else begin
      f9_nxt = F_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      f9_r  <= f9_nxt;
      tx9_r <= tx8_r;
      ty9_r <= ty8_r;
      x9_r  <= x8_r;
      y9_r  <= y8_r;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 10: partial products of x*F and y*F.
  // ---------------------------------------------------------------------------------------
  logic signed [64:0] xfl10_r, yfl10_r, xfl10_nxt, yfl10_nxt;
  logic signed [63:0] xfh10_r, yfh10_r, xfh10_nxt, yfh10_nxt;
  logic signed [99:0] tx10_r, ty10_r;

  always_comb begin
    xfl10_nxt = x9_r * $signed({1'b0, f9_r[31:0]});
    xfh10_nxt = x9_r * $signed(f9_r[63:32]);
    yfl10_nxt = y9_r * $signed({1'b0, f9_r[31:0]});
    yfh10_nxt = y9_r * $signed(f9_r[63:32]);
  end

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      xfl10_r <= xfl10_nxt;
      xfh10_r <= xfh10_nxt;
      yfl10_r <= yfl10_nxt;
      yfh10_r <= yfh10_nxt;
      tx10_r  <= tx9_r;
      ty10_r  <= ty9_r;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 11: assemble x*F and y*F (Q.48).
  // ---------------------------------------------------------------------------------------
  logic signed [95:0] xf11_r, yf11_r, xf11_nxt, yf11_nxt;
  logic signed [99:0] tx11_r, ty11_r;

  always_comb begin
    xf11_nxt = (96'(xfh10_r) <<< 32) + 96'(xfl10_r);
    yf11_nxt = (96'(yfh10_r) <<< 32) + 96'(yfl10_r);
  end

  always_ff @(posedge clk) begin
    if (adv[10]) begin
      xf11_r <= xf11_nxt;
      yf11_r <= yf11_nxt;
      tx11_r <= tx10_r;
      ty11_r <= ty10_r;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 12: radial moved to Q.60, plus tangential, plus rounding half.
  // ---------------------------------------------------------------------------------------
  logic signed [109:0] accx12_r, accy12_r, accx12_nxt, accy12_nxt;

  always_comb begin
    accx12_nxt = (110'(xf11_r) <<< 12) + 110'(tx11_r) + HALF_Q44;
    accy12_nxt = (110'(yf11_r) <<< 12) + 110'(ty11_r) + HALF_Q44;
  end

  always_ff @(posedge clk) begin
    if (adv[11]) begin
      accx12_r <= accx12_nxt;
      accy12_r <= accy12_nxt;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 13 (output register): shift down to Q16.16 and saturate.
  // ---------------------------------------------------------------------------------------
  logic signed [65:0] shx, shy;
  logic               fitx, fity;
  rtlm_out_t          out_r, out_nxt;

  always_comb begin
    shx  = $signed(accx12_r[109:44]);
    shy  = $signed(accy12_r[109:44]);
    fitx = (&shx[65:31]) || !(|shx[65:31]);
    fity = (&shy[65:31]) || !(|shy[65:31]);
    if (fitx) begin
      out_nxt.mapped_x = shx[31:0];
    end else begin
      out_nxt.mapped_x = shx[65] ? SAT_MIN : SAT_MAX;
    end
    if (fity) begin
      out_nxt.mapped_y = shy[31:0];
    end else begin
      out_nxt.mapped_y = shy[65] ? SAT_MIN : SAT_MAX;
    end
    out_nxt.saturated = !fitx || !fity;
  end

  always_ff @(posedge clk) begin
    if (adv[12]) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

  // ---------------------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------------------

  // A flagged result has at least one coordinate pinned to a limit.
  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.saturated) |->
      (out_data.mapped_x == SAT_MAX || out_data.mapped_x == SAT_MIN ||
       out_data.mapped_y == SAT_MAX || out_data.mapped_y == SAT_MIN))
    else $error("saturated flag without a clipped coordinate");

  // A full stage that cannot advance keeps its item and its scale factor.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[8] && !adv[8]) |=> (vld_r[8] && $stable(f9_r)))
    else $error("held pipeline stage lost or changed its item");

  // Reset leaves the pipeline empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (vld_r == '0))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking bench for the radial-tangential lens model: random and corner points over
// many coefficient settings, each result checked against an in-bench fixed-point mapping.
// Depends on rtlm_pkg and radial_tangential_lens_model.
`default_nettype none

module tb
  import rtlm_pkg::*;
();

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = STG_NUM + 4;
  localparam int unsigned RAND_PHASES    = 14;
  localparam int unsigned PHASE_POINTS   = 110;
  localparam int unsigned MAX_PRINTS     = 40;

  // idle patterns of either side, chosen per phase
  localparam int unsigned IDLE_NONE   = 0;
  localparam int unsigned IDLE_HEAVY  = 1;
  localparam int unsigned IDLE_SPARSE = 2;

  // coefficient flavors
  localparam int unsigned COEF_LENS = 0;
  localparam int unsigned COEF_EDGE = 1;
  localparam int unsigned COEF_WILD = 2;
  localparam int unsigned COEF_ZERO = 3;

  // wide-arithmetic bounds and constants of the mapping
  localparam logic signed [127:0] W_S64_MAX = {65'd0, {63{1'b1}}};
  localparam logic signed [127:0] W_S64_MIN = {{65{1'b1}}, 63'd0};
  localparam logic signed [127:0] W_S32_MAX = {97'd0, {31{1'b1}}};
  localparam logic signed [127:0] W_S32_MIN = {{97{1'b1}}, 31'd0};
  localparam logic signed [127:0] W_ONE     = {67'd0, 1'b1, 60'd0};
  localparam logic signed [127:0] W_HALF    = {84'd0, 1'b1, 43'd0};

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  rtlm_in_t             in_data   = '0;
  logic                 in_stall;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  rtlm_out_t            out_data;

  radial_tangential_lens_model u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Shadow copy of the coefficient registers, Q4.28, indexed by register code.
  logic signed [31:0] coef_sh [0:4] = '{default: '0};

  rtlm_in_t    point_q [$];   // points waiting to be offered
  rtlm_out_t   mapped_q [$];  // mapped points still owed by the block
  rtlm_out_t   want_r;

  logic        in_taken  = 1'b0;
  logic        out_taken = 1'b0;
  logic        send_hold = 1'b0;
  int unsigned send_mode = IDLE_NONE;
  int unsigned recv_mode = IDLE_NONE;
  int unsigned send_gap  = 0;
  int unsigned recv_wait = 0;
  int unsigned mismatch_count = 0;
  int unsigned result_count   = 0;
  int unsigned idle_cycles    = 0;

  // ---------------------------------------------------------------------------------------
  // Fixed-point mapping
  // ---------------------------------------------------------------------------------------

  function automatic logic signed [127:0] widen(input logic signed [31:0] v);
    return v;
  endfunction

  // Clamp a non-negative power term to 2^63 - 1.
  function automatic logic signed [127:0] cap63(input logic signed [127:0] v);
    return (v > W_S64_MAX) ? W_S64_MAX : v;
  endfunction

  // Round a Q.60 sum half up to Q16.16 and clip it to 32 bits.
  function automatic logic [31:0] round_clip(input logic signed [127:0] acc,
                                             output logic clip);
    logic signed [127:0] v;
    v = (acc + W_HALF) >>> 44;
    clip = 1'b0;
    if (v > W_S32_MAX) begin
      v = W_S32_MAX;
      clip = 1'b1;
    end else if (v < W_S32_MIN) begin
      v = W_S32_MIN;
      clip = 1'b1;
    end
    return v[31:0];
  endfunction

  function automatic rtlm_out_t distort_point(input rtlm_in_t pt);
    logic signed [127:0] x, y, xx, yy, xy, r2, r4, r6, poly, f, p1, p2, t, ax, ay;
    logic                clip_x, clip_y;
    rtlm_out_t           res;
    x  = widen(pt.point_x);
    y  = widen(pt.point_y);
    p1 = widen(coef_sh[CFG_P1]);
    p2 = widen(coef_sh[CFG_P2]);
    xx = x * x;
    yy = y * y;
    xy = x * y;
    // r2 only overflows 2^63-1 at the far corner; clamp it for the radial factor only
    r2 = cap63(xx + yy);
    r4 = cap63((r2 * r2) >>> 32);
    r6 = cap63((r4 * r2) >>> 32);
    poly = W_ONE + widen(coef_sh[CFG_K1]) * r2 + widen(coef_sh[CFG_K2]) * r4
         + widen(coef_sh[CFG_K3]) * r6;
    f = poly >>> 28;
    if (f > W_S64_MAX) begin
      f = W_S64_MAX;
    end else if (f < W_S64_MIN) begin
      f = W_S64_MIN;
    end
    // radial part x*F is Q.48; move it up to Q.60 next to the exact tangential part
    t  = p1 * xx;
    ax = ((x * f) <<< 12) + t + t + t + p1 * yy + ((p2 * xy) <<< 1);
    t  = p2 * yy;
    ay = ((y * f) <<< 12) + t + t + t + p2 * xx + ((p1 * xy) <<< 1);
    res.mapped_x  = round_clip(ax, clip_x);
    res.mapped_y  = round_clip(ay, clip_y);
    res.saturated = clip_x | clip_y;
    return res;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------------

  function automatic int unsigned draw_wait(input int unsigned mode);
    case (mode)
      IDLE_NONE:  return 0;
      IDLE_HEAVY: return $urandom_range(13);
      default:    return ($urandom_range(3) == 0) ? $urandom_range(13) : 0;
    endcase
  endfunction

  function automatic logic [31:0] pick_coef(input int unsigned kind);
    logic [31:0] r;
    r = $urandom();
    case (kind)
      COEF_LENS: return $signed(r) >>> $urandom_range(12, 2);
      COEF_EDGE: return r[0] ? SAT_MAX : SAT_MIN;
      COEF_ZERO: return '0;
      default:   return r;
    endcase
  endfunction

  // Mostly points within a few units of the center, where real lenses operate.
  function automatic logic [31:0] pick_coord();
    logic [31:0] r;
    int unsigned sel;
    r   = $urandom();
    sel = $urandom_range(9);
    if (sel <= 5) begin
      return $signed(r) >>> $urandom_range(20, 13);
    end
    if (sel == 6) begin
      return $signed(r) >>> $urandom_range(12, 1);
    end
    if (sel == 7) begin
      case ($urandom_range(4))
        0:       return SAT_MAX;
        1:       return SAT_MIN;
        2:       return '0;
        3:       return 32'd1;
        default: return '1;
      endcase
    end
    return r;
  endfunction

  function automatic rtlm_in_t corner_point(input int unsigned i);
    rtlm_in_t p;
    case (i)
      0:       p = {32'h0000_0000, 32'h0000_0000};
      1:       p = {SAT_MAX, SAT_MAX};
      2:       p = {SAT_MIN, SAT_MIN};            // only point where r2 reaches 2^63
      3:       p = {SAT_MIN, 32'h0001_0000};
      4:       p = {32'h0001_0000, 32'hFFFF_0000}; // (1.0, -1.0)
      5:       p = {32'h0000_8000, 32'h0000_4000};
      6:       p = {32'hFFFF_C000, 32'h0000_0001};
      default: p = {32'h0000_0001, 32'hFFFF_FFFF};
    endcase
    return p;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    // writes above the last register index are dropped by the block
    if (idx <= CFG_P2) begin
      coef_sh[idx] = val;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(input logic [31:0] k1, input logic [31:0] k2, input logic [31:0] k3,
                         input logic [31:0] p1, input logic [31:0] p2);
    write_reg(CFG_K1, k1);
    write_reg(CFG_K2, k2);
    write_reg(CFG_K3, k3);
    write_reg(CFG_P1, p1);
    write_reg(CFG_P2, p2);
  endtask

  task automatic poke_unused_index();
    write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, CFG_P2 + 1)), $urandom());
  endtask

  // Wait until every point is offered and answered, then let the pipeline run empty.
  task automatic settle();
    while (point_q.size() != 0 || in_valid || mapped_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) begin
      $display("ERROR result %0d %s: got %h, expected %h", result_count, what, got, want);
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Driver: offer queued points at the falling edge, idle between transfers
  // ---------------------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      // drop the point that just moved and draw the wait before the next one
      if (in_valid) begin
        void'(point_q.pop_front());
        send_gap = draw_wait(send_mode);
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (point_q.size() != 0 && !send_hold) begin
        in_valid <= 1'b1;
        in_data  <= point_q[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
    // otherwise hold the stalled point as it is
  end

  // Receiver: stall for a drawn number of cycles before each result transfer.
  always @(negedge clk) begin
    if (out_taken) begin
      recv_wait = draw_wait(recv_mode);
    end
    if (recv_wait > 0) begin
      recv_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor: predict on each input transfer, check each result transfer in order
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin
    in_taken  <= rst_n && in_valid && !in_stall;
    out_taken <= rst_n && out_valid && !out_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        mapped_q.push_back(distort_point(in_data));
      end
      if (out_valid && !out_stall) begin
        result_count++;
        if (mapped_q.size() == 0) begin
          report_mismatch("unexpected result", out_data.mapped_x, '0);
        end else begin
          want_r = mapped_q.pop_front();
          if (out_data.mapped_x !== want_r.mapped_x) begin
            report_mismatch("mapped_x", out_data.mapped_x, want_r.mapped_x);
          end
          if (out_data.mapped_y !== want_r.mapped_y) begin
            report_mismatch("mapped_y", out_data.mapped_y, want_r.mapped_y);
          end
          if (out_data.saturated !== want_r.saturated) begin
            report_mismatch("saturated", 32'(out_data.saturated), 32'(want_r.saturated));
          end
        end
      end
    end
  end

  // Watchdog: end the run if no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("radial_tangential_lens_model: mismatch");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------------------
  initial begin
    int unsigned base;
    int unsigned kind [0:4];

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Coefficients are zero after reset: the mapping must be the identity.
    send_mode = IDLE_HEAVY;
    recv_mode = IDLE_HEAVY;
    @(posedge clk);
    for (int unsigned i = 0; i < 8; i++) begin
      point_q.push_back(corner_point(i));
    end
    settle();

    // A typical barrel lens, then confirm a write to an unused index changes nothing.
    set_all(-32'sd75161928, 32'sd18790482, -32'sd268435, 32'sd322123, -32'sd241592);
    poke_unused_index();
    @(posedge clk);
    for (int unsigned i = 0; i < 8; i++) begin
      point_q.push_back(corner_point(i));
    end
    settle();

    // Largest positive coefficients: the powers clamp and the outputs clip.
    set_all(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX);
    @(posedge clk);
    for (int unsigned i = 0; i < 4; i++) begin
      point_q.push_back(corner_point(i));
    end
    settle();

    // Most negative coefficients: F clamps at the low bound.
    set_all(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);
    @(posedge clk);
    for (int unsigned i = 1; i < 5; i++) begin
      point_q.push_back(corner_point(i));
    end
    settle();

    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      // lens-like settings most often, else edge, wild or a per-coefficient mix with zero
      base = $urandom_range(5);
      for (int unsigned r = 0; r < 5; r++) begin
        case (base)
          0, 1:    kind[r] = COEF_LENS;
          2:       kind[r] = COEF_EDGE;
          3:       kind[r] = COEF_WILD;
          default: kind[r] = $urandom_range(COEF_ZERO);
        endcase
      end
      set_all(pick_coef(kind[0]), pick_coef(kind[1]), pick_coef(kind[2]),
              pick_coef(kind[3]), pick_coef(kind[4]));
      if ($urandom_range(3) == 0) begin
        poke_unused_index();
      end

      @(posedge clk);
      // keep the first phase at full rate on both sides
      send_mode = (ph == 0) ? IDLE_NONE : $urandom_range(IDLE_SPARSE);
      recv_mode = (ph == 0) ? IDLE_NONE : $urandom_range(IDLE_SPARSE);
      for (int unsigned n = 0; n < PHASE_POINTS; n++) begin
        point_q.push_back({pick_coord(), pick_coord()});
      end

      // Every fourth phase: stop offering midway until the pipeline has answered all.
      if (ph % 4 == 1) begin
        while (point_q.size() > PHASE_POINTS / 2) begin
          @(posedge clk);
        end
        send_hold = 1'b1;
        while (in_valid || mapped_q.size() != 0) begin
          @(posedge clk);
        end
        send_hold = 1'b0;
      end
      settle();
    end

    if (mismatch_count == 0) begin
      $display("radial_tangential_lens_model: match");
    end else begin
      $display("radial_tangential_lens_model: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
design/rtlm_pkg.sv
design/radial_tangential_lens_model.sv
test/tb.sv
